/* rtl/core/stereo_saturation_distortion_assert.svh */
// Assertion macros shared by the stereo saturation distortion RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef STEREO_SATURATION_DISTORTION_ASSERT_SVH
`define STEREO_SATURATION_DISTORTION_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define SSD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssd assertion failed");

// Next-cycle implication, disabled during reset.
`define SSD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssd assertion failed");

`else

`define SSD_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSD_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/ssd_pkg.sv */
// Package for the stereo saturation distortion block: types, Q8.24 constants
// and saturating fixed-point helpers. Depends on nothing.
`default_nettype none

package ssd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int CFG_INDEX_W = 8;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } frame_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } frame_out_t;

  // Control from the top level to one channel lane.
  typedef struct packed {
    logic start;
    q_t   sample;
    q_t   character;
    q_t   corrosion;
  } lane_ctl_t;

  // Status from one channel lane back to the top level.
  typedef struct packed {
    logic done;
    q_t   result;
  } lane_stat_t;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_CHARACTER = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CORROSION = CFG_INDEX_W'(1);

  localparam logic [15:0] Q15_ONE        = 16'd32768;
  localparam logic [15:0] CHARACTER_INIT = 16'd11469;

  // Q8.24 constants.
  localparam q_t Q_ONE   = 32'sd16777216;
  localparam q_t K_SLEW  = 32'sd25166;
  localparam q_t K_0P35  = 32'sd5872026;
  localparam q_t K_27    = 32'sd452984832;
  localparam q_t K_HALF  = 32'sd8388608;
  localparam q_t K_0P38  = 32'sd6375342;
  localparam q_t K_0P006 = 32'sd100663;
  localparam q_t K_0P105 = 32'sd1761608;
  localparam q_t K_0P82  = 32'sd13757317;
  localparam q_t K_0P30  = 32'sd5033165;
  localparam q_t K_0P45  = 32'sd7549747;
  localparam q_t K_0P010 = 32'sd167772;
  localparam q_t K_0P16  = 32'sd2684355;
  localparam q_t K_1P16  = 32'sd19461571;
  localparam q_t K_0P48  = 32'sd8053064;
  localparam q_t K_0P18  = 32'sd3019899;
  localparam q_t K_1P95  = 32'sd32715571;
  localparam q_t K_17    = 32'sd285212672;
  localparam q_t K_0P24  = 32'sd4026532;
  localparam q_t K_0P66  = 32'sd11072963;
  localparam q_t K_0P65  = 32'sd10905190;
  localparam q_t K_7     = 32'sd117440512;
  localparam q_t K_0P25  = 32'sd4194304;
  localparam q_t K_1P55  = 32'sd26004685;
  localparam q_t K_0P018 = 32'sd301990;
  localparam q_t K_0P72  = 32'sd12079596;
  localparam q_t K_ENV   = 32'sd16777;
  localparam q_t K_0P025 = 32'sd419430;
  localparam q_t K_0P15  = 32'sd2516582;

  // Sample scaling between SAMPLE_BITS and Q8.24 (full scale is 2^25 LSBs).
  localparam int IN_SHL  = (SAMPLE_BITS <= 25) ? 25 - SAMPLE_BITS : 0;
  localparam int IN_SHR  = (SAMPLE_BITS > 25) ? SAMPLE_BITS - 25 : 0;
  localparam int OUT_SHR = IN_SHL;
  localparam int OUT_SHL = IN_SHR;
  localparam logic signed [47:0] IN_RND  = (48'sd1 <<< IN_SHR) >>> 1;
  localparam logic signed [47:0] OUT_RND = (48'sd1 <<< OUT_SHR) >>> 1;
  localparam logic signed [47:0] SMP_MAX = (48'sd1 <<< (SAMPLE_BITS - 1)) - 48'sd1;
  localparam logic signed [47:0] SMP_MIN = -(48'sd1 <<< (SAMPLE_BITS - 1));

  // Saturate a wide signed value to the 32-bit range.
  function automatic q_t sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -48'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic q_t add_q(input q_t a, input q_t b);
    return sat32(48'(a) + 48'(b));
  endfunction

  function automatic q_t sub_q(input q_t a, input q_t b);
    return sat32(48'(a) - 48'(b));
  endfunction

  function automatic q_t abs_q(input q_t a);
    return sat32(a[31] ? -48'(a) : 48'(a));
  endfunction

  // Round a full product to Q8.24, half up, then saturate.
  function automatic q_t round_q(input logic signed [65:0] p);
    logic signed [65:0] r;
    r = (p + 66'sd8388608) >>> 24;
    return sat32(r[47:0]);
  endfunction

  function automatic q_t mul_q(input q_t a, input q_t b);
    logic signed [65:0] p;
    p = a * b;
    return round_q(p);
  endfunction

  function automatic q_t sample_in(input logic signed [SAMPLE_BITS-1:0] s);
    logic signed [47:0] w;
    w = ((48'(s) <<< IN_SHL) + IN_RND) >>> IN_SHR;
    return sat32(w);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sample_out(input q_t y);
    logic signed [47:0] v;
    v = ((48'(y) + OUT_RND) >>> OUT_SHR) <<< OUT_SHL;
    if (v > SMP_MAX) begin
      v = SMP_MAX;
    end
    if (v < SMP_MIN) begin
      v = SMP_MIN;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ssd_div.sv */
// Radix-2 restoring divider that yields a 25-bit quotient, one bit a cycle.
// Depends on ssd_pkg only for house conventions; the quotient must be below 2^25.
`default_nettype none

module ssd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [41:0] den,
  output logic        done,
  output logic [24:0] quot
);
  import ssd_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] rem;
  logic [65:0] sdiv;
  logic        ge;

  // Trial subtraction of the shifted divisor.
  assign ge = {2'b00, rem} >= sdiv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        sdiv <= {den, 24'b0};
        quot <= 25'd0;
        cnt  <= 5'd24;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - sdiv[63:0];
        end
        quot <= {quot[23:0], ge};
        sdiv <= sdiv >> 1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  `include "stereo_saturation_distortion_assert.svh"

  `SSD_ASSERT_IMP(a_start_idle, clk, rst, start, !busy)
  `SSD_ASSERT_NXT(a_last_done, clk, rst, busy && cnt == 5'd0 && !start, done)
  `SSD_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)

endmodule

`default_nettype wire

/* rtl/core/ssd_lane.sv */
// One channel lane: a sequencer around a single multiplier and a divider
// that runs the whole per-channel chain. Depends on ssd_pkg and ssd_div.
`default_nettype none

module ssd_lane (
  input  logic               clk,
  input  logic               rst,
  input  ssd_pkg::lane_ctl_t  ctl,
  output ssd_pkg::lane_stat_t stat
);
  import ssd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE, ST_PRE_K, ST_PRE_LP, ST_TILT_LO_K, ST_TILT_LO, ST_TILT_HI_K,
    ST_TILT_HI, ST_DRV_SQ, ST_DRV_K, ST_DRV, ST_ASYM_K, ST_BIAS, ST_SAT1,
    ST_SAT2, ST_SHAPED, ST_DZ_AMT_K, ST_DZ_AMT, ST_DZ_THR, ST_DZ_GAIN,
    ST_DZ_KNEE, ST_DZ, ST_GAIN_K, ST_GAIN, ST_HIGH_K, ST_HIGH, ST_SAT3,
    ST_POST_K, ST_POST_LP, ST_BLEND_K, ST_BLEND, ST_ENV_IN, ST_ENV_OUT,
    ST_RATIO, ST_RATIO_DIV, ST_RATIO_WAIT, ST_MATCH, ST_WET_K, ST_WET,
    ST_MIX, ST_SS_SQ, ST_SS_WAIT, ST_SS_MUL
  } state_t;

  state_t st;
  state_t ret;

  // Filter state.
  q_t pl;
  q_t pol;
  q_t ie;
  q_t oe;

  // Working registers.
  q_t x, chv, cor, ax, k, acc, t, high, shaped, y, amt, thr;
  q_t sv, ssr, cleaned, num, den, match, res;
  logic done;

  // Shared multiplier.
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod;
  q_t mq;

  // Divider hookup.
  logic        div_start;
  logic [63:0] div_num;
  logic [41:0] div_den;
  logic        div_done;
  logic [24:0] quot;

  // Soft saturation terms.
  logic [38:0] x2;
  logic [39:0] ss_num;
  logic [41:0] ss_den;

  // Dead-zone terms.
  logic signed [32:0] ya;
  logic               dz_in;
  logic signed [33:0] dz_s;
  logic signed [33:0] dz_c;
  q_t dz_out;

  // Level match terms.
  q_t den_raw;
  q_t mix;

  // Operand selection for the one multiplier.
  always_comb begin
    ma = 33'sd0;
    mb = 33'sd0;
    unique case (st)
      ST_PRE_K:     begin ma = 33'(K_0P16); mb = 33'(chv); end
      ST_PRE_LP:    begin ma = 33'(sub_q(x, pl)); mb = 33'(k); end
      ST_TILT_LO_K: begin ma = 33'(K_0P48); mb = 33'(chv); end
      ST_TILT_LO:   begin ma = 33'(pl); mb = 33'(k); end
      ST_TILT_HI_K: begin ma = 33'(K_1P95); mb = 33'(chv); end
      ST_TILT_HI:   begin ma = 33'(high); mb = 33'(k); end
      ST_DRV_SQ:    begin ma = 33'(cor); mb = 33'(cor); end
      ST_DRV_K:     begin ma = 33'(K_17); mb = 33'(t); end
      ST_DRV:       begin ma = 33'(shaped); mb = 33'(k); end
      ST_ASYM_K:    begin ma = 33'(K_0P66); mb = 33'(chv); end
      ST_BIAS:      begin ma = 33'(sub_q(k, K_HALF)); mb = 33'(K_0P38); end
      ST_DZ_AMT_K:  begin ma = 33'(K_0P65); mb = 33'(chv); end
      ST_DZ_AMT:    begin ma = 33'(cor); mb = 33'(k); end
      ST_DZ_THR:    begin ma = 33'(K_0P105); mb = 33'(amt); end
      ST_DZ_GAIN:   begin ma = 33'(K_0P82); mb = 33'(amt); end
      ST_DZ_KNEE:   begin ma = 33'(K_0P45); mb = 33'(amt); end
      ST_DZ: begin
        if (dz_in) begin
          ma = 33'(y);
          mb = 33'(k);
        end else begin
          ma = 33'(thr);
          mb = 33'(t);
        end
      end
      ST_GAIN_K:    begin ma = 33'(K_7); mb = 33'(cor); end
      ST_GAIN:      begin ma = 33'(y); mb = 33'(k); end
      ST_HIGH_K:    begin ma = 33'(K_1P55); mb = 33'(chv); end
      ST_HIGH:      begin ma = 33'(high); mb = 33'(k); end
      ST_SAT3:      begin ma = 33'(t); mb = 33'(cor); end
      ST_POST_K:    begin ma = 33'(K_0P24); mb = 33'(chv); end
      ST_POST_LP:   begin ma = 33'(sub_q(y, pol)); mb = 33'(k); end
      ST_BLEND_K:   begin ma = 33'(K_0P72); mb = 33'(chv); end
      ST_BLEND:     begin ma = 33'(sub_q(y, pol)); mb = 33'(k); end
      ST_ENV_IN:    begin ma = 33'(sub_q(ax, ie)); mb = 33'(K_ENV); end
      ST_ENV_OUT:   begin ma = 33'(sub_q(abs_q(cleaned), oe)); mb = 33'(K_ENV); end
      ST_MATCH:     begin ma = 33'(cleaned); mb = 33'(match); end
      ST_WET_K:     begin ma = 33'(K_0P30); mb = 33'(cor); end
      ST_WET:       begin ma = 33'(acc); mb = 33'(k); end
      ST_MIX:       begin ma = 33'(sub_q(t, x)); mb = 33'(cor); end
      ST_SS_SQ: begin
        ma = sv[31] ? -33'(sv) : 33'(sv);
        mb = ma;
      end
      ST_SS_MUL:    begin ma = 33'(sv); mb = {8'b0, quot}; end
      default:      begin ma = 33'sd0; mb = 33'sd0; end
    endcase
  end

  assign prod = ma * mb;
  assign mq   = round_q(prod);

  // Soft saturation ratio (27 + x^2) / (27 + 9 x^2) feeds the divider.
  always_comb begin
    logic signed [65:0] x2w;
    x2w    = (prod + 66'sd8388608) >>> 24;
    x2     = x2w[38:0];
    ss_num = 40'(x2) + 40'(K_27);
    ss_den = 42'(x2) + (42'(x2) << 3) + 42'(K_27);
  end

  // Dead-zone compare and knee subtraction.
  always_comb begin
    ya     = y[31] ? -33'(y) : 33'(y);
    dz_in  = ya <= 33'(thr);
    dz_s   = 34'(ya) - 34'(mq);
    dz_c   = dz_s[33] ? 34'sd0 : dz_s;
    dz_out = sat32(y[31] ? -48'(dz_c) : 48'(dz_c));
  end

  assign den_raw = add_q(oe, K_0P025);
  assign mix     = add_q(x, mq);

  // Divider requests: soft saturation and the level-match ratio.
  assign div_start = (st == ST_SS_SQ) ||
                     ((st == ST_RATIO_DIV) && (num > 32'sd0) && (num < den));
  assign div_num   = (st == ST_SS_SQ) ? {ss_num, 24'b0} : {8'b0, num, 24'b0};
  assign div_den   = (st == ST_SS_SQ) ? ss_den : 42'(den);

  ssd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // Sequencer: state, filter state and results.
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_IDLE;
      ret  <= ST_IDLE;
      done <= 1'b0;
      pl   <= '0;
      pol  <= '0;
      ie   <= '0;
      oe   <= '0;
    end else begin
      done <= 1'b0;
      unique case (st)
        ST_IDLE: begin
          if (ctl.start) begin
            x   <= ctl.sample;
            chv <= ctl.character;
            cor <= ctl.corrosion;
            ax  <= abs_q(ctl.sample);
            st  <= ST_PRE_K;
          end
        end
        ST_PRE_K:     begin k <= add_q(K_0P010, mq); st <= ST_PRE_LP; end
        ST_PRE_LP:    begin pl <= add_q(pl, mq); st <= ST_TILT_LO_K; end
        ST_TILT_LO_K: begin
          high <= sub_q(x, pl);
          k    <= sub_q(K_1P16, mq);
          st   <= ST_TILT_LO;
        end
        ST_TILT_LO:   begin acc <= mq; st <= ST_TILT_HI_K; end
        ST_TILT_HI_K: begin k <= add_q(K_0P18, mq); st <= ST_TILT_HI; end
        ST_TILT_HI:   begin shaped <= add_q(acc, mq); st <= ST_DRV_SQ; end
        ST_DRV_SQ:    begin t <= mq; st <= ST_DRV_K; end
        ST_DRV_K:     begin k <= add_q(Q_ONE, mq); st <= ST_DRV; end
        ST_DRV:       begin acc <= mq; st <= ST_ASYM_K; end
        ST_ASYM_K:    begin k <= add_q(K_0P24, mq); st <= ST_BIAS; end
        ST_BIAS:      begin t <= mq; st <= ST_SAT1; end
        ST_SAT1: begin
          sv  <= add_q(acc, t);
          ret <= ST_SAT2;
          st  <= ST_SS_SQ;
        end
        ST_SAT2: begin
          y   <= ssr;
          sv  <= t;
          ret <= ST_SHAPED;
          st  <= ST_SS_SQ;
        end
        ST_SHAPED:    begin y <= sub_q(y, ssr); st <= ST_DZ_AMT_K; end
        ST_DZ_AMT_K:  begin k <= add_q(K_0P35, mq); st <= ST_DZ_AMT; end
        ST_DZ_AMT:    begin amt <= mq; st <= ST_DZ_THR; end
        ST_DZ_THR:    begin thr <= add_q(K_0P006, mq); st <= ST_DZ_GAIN; end
        ST_DZ_GAIN:   begin k <= sub_q(Q_ONE, mq); st <= ST_DZ_KNEE; end
        ST_DZ_KNEE:   begin t <= add_q(K_0P30, mq); st <= ST_DZ; end
        ST_DZ: begin
          y  <= dz_in ? mq : dz_out;
          st <= ST_GAIN_K;
        end
        ST_GAIN_K:    begin k <= add_q(Q_ONE, mq); st <= ST_GAIN; end
        ST_GAIN:      begin acc <= mq; st <= ST_HIGH_K; end
        ST_HIGH_K:    begin k <= add_q(K_0P25, mq); st <= ST_HIGH; end
        ST_HIGH:      begin t <= mq; st <= ST_SAT3; end
        ST_SAT3: begin
          sv  <= add_q(acc, mq);
          ret <= ST_POST_K;
          st  <= ST_SS_SQ;
        end
        ST_POST_K: begin
          y  <= ssr;
          k  <= add_q(K_0P018, mq);
          st <= ST_POST_LP;
        end
        ST_POST_LP:   begin pol <= add_q(pol, mq); st <= ST_BLEND_K; end
        ST_BLEND_K:   begin k <= add_q(K_0P18, mq); st <= ST_BLEND; end
        ST_BLEND:     begin cleaned <= add_q(pol, mq); st <= ST_ENV_IN; end
        ST_ENV_IN:    begin ie <= add_q(ie, mq); st <= ST_ENV_OUT; end
        ST_ENV_OUT:   begin oe <= add_q(oe, mq); st <= ST_RATIO; end
        ST_RATIO: begin
          num <= add_q(ie, K_0P025);
          den <= (den_raw < 32'sd1) ? 32'sd1 : den_raw;
          st  <= ST_RATIO_DIV;
        end
        // Ratios that clamp need no division.
        ST_RATIO_DIV: begin
          if (num <= 32'sd0) begin
            match <= K_0P15;
            st    <= ST_MATCH;
          end else if (num >= den) begin
            match <= Q_ONE;
            st    <= ST_MATCH;
          end else begin
            st <= ST_RATIO_WAIT;
          end
        end
        ST_RATIO_WAIT: begin
          if (div_done) begin
            match <= (q_t'({7'b0, quot}) < K_0P15) ? K_0P15 : q_t'({7'b0, quot});
            st    <= ST_MATCH;
          end
        end
        ST_MATCH:     begin acc <= mq; st <= ST_WET_K; end
        ST_WET_K:     begin k <= sub_q(Q_ONE, mq); st <= ST_WET; end
        ST_WET:       begin t <= mq; st <= ST_MIX; end
        ST_MIX: begin
          if (mix > Q_ONE) begin
            res <= Q_ONE;
          end else if (mix < -Q_ONE) begin
            res <= -Q_ONE;
          end else begin
            res <= mix;
          end
          done <= 1'b1;
          st   <= ST_IDLE;
        end
        // Soft saturation subroutine: square, divide, scale.
        ST_SS_SQ:     st <= ST_SS_WAIT;
        ST_SS_WAIT: begin
          if (div_done) begin
            st <= ST_SS_MUL;
          end
        end
        ST_SS_MUL:    begin ssr <= mq; st <= ret; end
        default:      st <= ST_IDLE;
      endcase
    end
  end

  assign stat.done   = done;
  assign stat.result = res;

  `include "stereo_saturation_distortion_assert.svh"

  `SSD_ASSERT_IMP(a_start_idle, clk, rst, ctl.start, st == ST_IDLE)
  `SSD_ASSERT_IMP(a_div_waited, clk, rst, div_done, st == ST_SS_WAIT || st == ST_RATIO_WAIT)
  `SSD_ASSERT_IMP(a_res_range, clk, rst, done, res <= Q_ONE && res >= -Q_ONE)

endmodule

`default_nettype wire

/* rtl/core/ssd_merge.sv */
// Merging stage: joins the two lane results into one output frame, scales
// them to sample width and holds the output register. Depends on ssd_pkg.
`default_nettype none

module ssd_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  ssd_pkg::q_t         left,
  input  ssd_pkg::q_t         right,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output ssd_pkg::frame_out_t out_frame
);
  import ssd_pkg::*;

  // The register can take a frame when empty or being emptied.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid           <= 1'b1;
      out_frame.left_out  <= sample_out(left);
      out_frame.right_out <= sample_out(right);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stereo_saturation_distortion.sv */
// Stereo saturation distortion top level: configuration, control smoothing,
// two channel lanes and the output merge. Depends on ssd_pkg, ssd_lane, ssd_merge.
`default_nettype none

// One request on the input channel carries a stereo frame and gives one
// output frame. The block works on one frame at a time. The ST_SLEW_CH and
// ST_SLEW_COR states slew the smoothed character and corrosion controls,
// and a registered lane_start launches the lanes; the left and right lanes
// then run side by side, each a sequencer of 37 single-step states around
// one multiplier plus a one-bit-per-cycle divider, used for the three
// soft saturations and for level matching; level matching needs no
// division when its ratio clamps. The lane done flags are registered in
// l_fin and r_fin; once both are set and the output register is free, the
// results are loaded into it and the block goes idle. A finished frame sits
// in the output register, so the next request is taken while it waits.
// Configuration writes are always accepted; write them while idle.
module stereo_saturation_distortion (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ssd_pkg::frame_in_t                in_frame,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ssd_pkg::frame_out_t               out_frame,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [15:0]                       cfg_data
);
  import ssd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SLEW_CH, ST_SLEW_COR, ST_RUN} state_t;

  state_t st;
  logic [15:0] ct;
  logic [15:0] rt;
  q_t cs;
  q_t cr;
  q_t xl;
  q_t xr;
  logic lane_start;
  logic l_fin;
  logic r_fin;

  q_t diff;
  q_t mq;
  logic [15:0] cfg_clamped;
  logic load;
  logic free;

  lane_ctl_t  l_ctl;
  lane_ctl_t  r_ctl;
  lane_stat_t l_stat;
  lane_stat_t r_stat;

  assign cfg_ready   = 1'b1;
  assign cfg_clamped = (cfg_data > Q15_ONE) ? Q15_ONE : cfg_data;
  assign in_ready    = (st == ST_IDLE);

  // Slew step shared by both controls.
  assign diff = (st == ST_SLEW_CH) ? sub_q(q_t'({7'b0, ct, 9'b0}), cs)
                                   : sub_q(q_t'({7'b0, rt, 9'b0}), cr);
  assign mq   = mul_q(diff, K_SLEW);

  assign load = (st == ST_RUN) && l_fin && r_fin && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      ct         <= CHARACTER_INIT;
      rt         <= 16'd0;
      cs         <= K_0P35;
      cr         <= '0;
      lane_start <= 1'b0;
      l_fin      <= 1'b0;
      r_fin      <= 1'b0;
    end else begin
      lane_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CHARACTER) begin
          ct <= cfg_clamped;
        end else if (cfg_index == REG_CORROSION) begin
          rt <= cfg_clamped;
        end
      end
      if (l_stat.done) begin
        l_fin <= 1'b1;
      end
      if (r_stat.done) begin
        r_fin <= 1'b1;
      end
      unique case (st)
        ST_IDLE: begin
          if (in_valid) begin
            xl    <= sample_in(in_frame.left_sample);
            xr    <= sample_in(in_frame.right_sample);
            l_fin <= 1'b0;
            r_fin <= 1'b0;
            st    <= ST_SLEW_CH;
          end
        end
        ST_SLEW_CH: begin
          cs <= add_q(cs, mq);
          st <= ST_SLEW_COR;
        end
        ST_SLEW_COR: begin
          cr         <= add_q(cr, mq);
          lane_start <= 1'b1;
          st         <= ST_RUN;
        end
        ST_RUN: begin
          if (load) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Lane requests.
  assign l_ctl.start     = lane_start;
  assign l_ctl.sample    = xl;
  assign l_ctl.character = cs;
  assign l_ctl.corrosion = cr;
  assign r_ctl.start     = lane_start;
  assign r_ctl.sample    = xr;
  assign r_ctl.character = cs;
  assign r_ctl.corrosion = cr;

  ssd_lane u_lane_l (
    .clk  (clk),
    .rst  (rst),
    .ctl  (l_ctl),
    .stat (l_stat)
  );

  ssd_lane u_lane_r (
    .clk  (clk),
    .rst  (rst),
    .ctl  (r_ctl),
    .stat (r_stat)
  );

  ssd_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .left      (l_stat.result),
    .right     (r_stat.result),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_frame (out_frame)
  );

  `include "stereo_saturation_distortion_assert.svh"

  `SSD_ASSERT_NXT(a_one_frame, clk, rst, in_valid && in_ready, !in_ready)
  `SSD_ASSERT_IMP(a_lane_done_run, clk, rst, l_stat.done || r_stat.done, st == ST_RUN)
  `SSD_ASSERT_NXT(a_load_shows, clk, rst, load, out_valid && in_ready)

endmodule

`default_nettype wire
